// File: src/aes128_block_cipher_core_assert.svh
// assertion macros for the aes-128 core
`ifndef AES128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES128_BLOCK_CIPHER_CORE_ASSERT_SVH
// property a must imply property b in the next cycle
`define AES_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// combinational invariant
`define AES_ASSERT_ALWAYS(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) (a)) \
      else $error("assertion failed");
`endif

// File: src/aes_pkg.sv
// ---------------------------------------------------------------------------
// aes_pkg
// shared types, tables and round functions of the aes-128 core
// ---------------------------------------------------------------------------
package aes_pkg;

   localparam int NumRounds = 10;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } stage_ctl_type;

   typedef logic [NumRounds:0][127:0] key_set_type;

   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [7:0] r;
      case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   // inverse box found by search over the forward box
   function automatic logic [7:0] sbox_rev(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (sbox(8'(i)) == v) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // state byte i lives at bits [127-8i -: 8]
   function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
      return s[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input op_type op);
      logic [127:0] t;
      int src;
      t = '0;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            if (op == OP_DECRYPT) begin
               src = (col + 4 - row) & 3;
               t[127-8*(row+4*col) -: 8] = sbox_rev(get_b(s, row + 4*src));
            end else begin
               src = (col + row) & 3;
               t[127-8*(row+4*col) -: 8] = sbox(get_b(s, row + 4*src));
            end
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input op_type op);
      logic [127:0] t;
      logic [7:0] c [4];
      logic [7:0] c2 [4];
      logic [7:0] c4 [4];
      logic [7:0] c8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      t = '0;
      for (int col = 0; col < 4; col++) begin
         for (int k = 0; k < 4; k++) begin
            c[k] = get_b(s, 4*col + k);
            c2[k] = xt(c[k]);
            c4[k] = xt(c2[k]);
            c8[k] = xt(c4[k]);
            m2[k] = c2[k];
            m3[k] = c2[k] ^ c[k];
            m9[k] = c8[k] ^ c[k];
            mb[k] = c8[k] ^ c2[k] ^ c[k];
            md[k] = c8[k] ^ c4[k] ^ c[k];
            me[k] = c8[k] ^ c4[k] ^ c2[k];
         end
         for (int row = 0; row < 4; row++) begin
            if (op == OP_DECRYPT) begin
               t[127-8*(4*col+row) -: 8] = me[row] ^ mb[(row+1)&3]
                  ^ md[(row+2)&3] ^ m9[(row+3)&3];
            end else begin
               t[127-8*(4*col+row) -: 8] = m2[row] ^ m3[(row+1)&3]
                  ^ c[(row+2)&3] ^ c[(row+3)&3];
            end
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [127:0] n;
      logic [31:0] t;
      t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
      n[127:96] = k[127:96] ^ t;
      n[95:64] = k[95:64] ^ n[127:96];
      n[63:32] = k[63:32] ^ n[95:64];
      n[31:0] = k[31:0] ^ n[63:32];
      return n;
   endfunction

endpackage

// File: src/aes_key_sched.sv
// ---------------------------------------------------------------------------
// aes_key_sched
// key registers and a one-round-per-cycle key expansion into the round keys
// ---------------------------------------------------------------------------
module aes_key_sched (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [0:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  logic                index_ok,
   output aes_pkg::key_set_type key_set
);

   logic [127:0] key_ff, key_in;
   logic [127:0] cur_ff, cur_in;
   logic [7:0]   rc_ff, rc_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         run_ff, run_in;
   aes_pkg::key_set_type keys_ff, keys_in;

   always_comb begin
      key_in = key_ff;
      cur_in = cur_ff;
      rc_in = rc_ff;
      rnd_in = rnd_ff;
      run_in = run_ff;
      keys_in = keys_ff;
      if (csr_write && index_ok) begin
         if (aes_pkg::csr_index_type'(csr_index) == aes_pkg::CSR_KEY_HIGH) begin
            key_in[127:64] = csr_wdata;
         end else begin
            key_in[63:0] = csr_wdata;
         end
         cur_in = key_in;
         keys_in[0] = key_in;
         rc_in = 8'h01;
         rnd_in = 4'd1;
         run_in = 1'b1;
      end else if (run_ff) begin
         cur_in = aes_pkg::next_key(cur_ff, rc_ff);
         keys_in[rnd_ff] = cur_in;
         rc_in = aes_pkg::xt(rc_ff);
         rnd_in = rnd_ff + 4'd1;
         run_in = (rnd_ff != 4'(aes_pkg::NumRounds));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         run_ff <= 1'b0;
         rnd_ff <= '0;
      end else begin
         key_ff <= key_in;
         run_ff <= run_in;
         rnd_ff <= rnd_in;
      end
      cur_ff <= cur_in;
      rc_ff <= rc_in;
      keys_ff <= keys_in;
   end

   assign key_set = keys_ff;

endmodule

// File: src/aes_round_stage.sv
// ---------------------------------------------------------------------------
// aes_round_stage
// one registered cipher round, forward or inverse per transaction
// ---------------------------------------------------------------------------
module aes_round_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  aes_pkg::stage_ctl_type ctl_i,
   input  logic [127:0]         state_i,
   input  logic [127:0]         key_i,
   input  logic                 last,
   output aes_pkg::stage_ctl_type ctl_o,
   output logic [127:0]         state_o
);

   aes_pkg::stage_ctl_type ctl_ff;
   logic [127:0] st_ff, st_in, ss;

   always_comb begin
      ss = aes_pkg::sub_shift(state_i, ctl_i.op);
      if (last) begin
         st_in = ss ^ key_i;
      end else if (ctl_i.op == aes_pkg::OP_DECRYPT) begin
         st_in = aes_pkg::mix(ss ^ key_i, aes_pkg::OP_DECRYPT);
      end else begin
         st_in = aes_pkg::mix(ss, aes_pkg::OP_ENCRYPT) ^ key_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      st_ff <= st_in;
   end

   assign ctl_o = ctl_ff;
   assign state_o = st_ff;

endmodule

// File: src/aes128_block_cipher_core.sv
// ---------------------------------------------------------------------------
// aes128_block_cipher_core
// aes-128 ecb encrypt and decrypt, eleven stage round pipeline
// ---------------------------------------------------------------------------
// A block is taken on any cycle with start high and appears on rsp_out_* with
// rsp_valid high after the input key-add stage and one register stage per
// cipher round; one block per cycle sustained. busy is never high. After a
// key write the round keys are expanded one round per cycle, so allow the
// expansion to finish before the next start; the core does not enforce this.
`include "aes128_block_cipher_core_assert.svh"

module aes128_block_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int N = aes_pkg::NumRounds;

   aes_pkg::key_set_type rk;
   aes_pkg::stage_ctl_type ctl [N+1];
   logic [127:0] st [N+1];
   aes_pkg::stage_ctl_type ctl0_ff;
   logic [127:0] st0_ff, k0;

   aes_key_sched u_keys (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .index_ok(1'b1),
      .key_set(rk)
   );

   assign busy = 1'b0;
   assign k0 = (aes_pkg::op_type'(req_operation) == aes_pkg::OP_DECRYPT) ? rk[N] : rk[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else begin
         ctl0_ff <= '{valid: start, op: aes_pkg::op_type'(req_operation)};
      end
      st0_ff <= {req_data_high, req_data_low} ^ k0;
   end

   assign ctl[0] = ctl0_ff;
   assign st[0] = st0_ff;

   for (genvar r = 1; r <= N; r++) begin : g_round
      aes_round_stage u_round (
         .clock(clock), .reset(reset), .ctl_i(ctl[r-1]), .state_i(st[r-1]),
         .key_i(ctl[r-1].op == aes_pkg::OP_DECRYPT ? rk[N-r] : rk[r]),
         .last(r == N), .ctl_o(ctl[r]), .state_o(st[r])
      );
   end

   assign rsp_valid = ctl[N].valid;
   assign rsp_out_high = st[N][127:64];
   assign rsp_out_low = st[N][63:0];

   `AES_ASSERT_NEXT(a_enter, clock, reset, start, ctl[0].valid)
   `AES_ASSERT_NEXT(a_flow, clock, reset, ctl[N-1].valid, rsp_valid)
   `AES_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

endmodule

// File: bench/tb_aes128_block_cipher_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aes128_block_cipher_core
// self-checking bench for the aes-128 ecb core: known-answer rows, then random
// blocks under several keys, checked against known answers or a behavioral cipher
// ---------------------------------------------------------------------------
module tb_aes128_block_cipher_core;

   localparam int StallLimit = 3000;
   localparam int KeySettle  = 16;
   localparam int RandBlocks = 1130;

   typedef struct {
      logic [63:0]     key_hi;
      logic [63:0]     key_lo;
      aes_pkg::op_type op;
      logic [63:0]     din_hi;
      logic [63:0]     din_lo;
      bit              known;
      logic [63:0]     dout_hi;
      logic [63:0]     dout_lo;
   } kat_row_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [63:0] req_data_high;
   logic [63:0] req_data_low;
   logic        rsp_valid;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [63:0] csr_wdata;

   logic [7:0]   fwd_sub [256];
   logic [7:0]   inv_sub [256];
   logic [127:0] model_keys [11];
   logic [63:0]  key_hi_q;
   logic [63:0]  key_lo_q;
   block_type    pending_blocks [$];
   int           errors;
   int           stall_cycles;

   aes128_block_cipher_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_data_high(req_data_high),
      .req_data_low(req_data_low), .rsp_valid(rsp_valid),
      .rsp_out_high(rsp_out_high), .rsp_out_low(rsp_out_low),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // substitution boxes built from the field inverse and the affine map
   task automatic build_boxes();
      logic [7:0] v;
      logic [7:0] y;
      for (int x = 0; x < 256; x++) begin
         v = 8'h00;
         for (int c = 1; c < 256; c++) begin
            if (gf_mul(8'(x), 8'(c)) == 8'h01) v = 8'(c);
         end
         y = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
            ^ {v[3:0], v[7:4]} ^ 8'h63;
         fwd_sub[x] = y;
         inv_sub[y] = 8'(x);
      end
   endtask

   task automatic expand_keys();
      logic [7:0] cur [16];
      logic [7:0] t [4];
      logic [7:0] rc;
      logic [127:0] k;
      rc = 8'h01;
      k = {key_hi_q, key_lo_q};
      for (int i = 0; i < 16; i++) cur[i] = k[127-8*i -: 8];
      model_keys[0] = k;
      for (int r = 1; r <= 10; r++) begin
         t[0] = fwd_sub[cur[13]] ^ rc;
         t[1] = fwd_sub[cur[14]];
         t[2] = fwd_sub[cur[15]];
         t[3] = fwd_sub[cur[12]];
         for (int j = 0; j < 4; j++) cur[j] ^= t[j];
         for (int j = 4; j < 16; j++) cur[j] ^= cur[j-4];
         for (int i = 0; i < 16; i++) model_keys[r][127-8*i -: 8] = cur[i];
         rc = gf_mul(rc, 8'h02);
      end
   endtask

   function automatic logic [127:0] sub_rows(input logic [127:0] s, input bit inv);
      logic [127:0] t;
      int src;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            src = inv ? (col + 4 - row) & 3 : (col + row) & 3;
            t[127-8*(row+4*col) -: 8] = inv ? inv_sub[s[127-8*(row+4*src) -: 8]]
                                            : fwd_sub[s[127-8*(row+4*src) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit inv);
      logic [7:0] coef [4];
      logic [7:0] acc;
      logic [127:0] t;
      if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) begin
               acc ^= gf_mul(s[127-8*(4*col+k) -: 8], coef[(k + 4 - row) & 3]);
            end
            t[127-8*(4*col+row) -: 8] = acc;
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] aes_cipher(input aes_pkg::op_type op,
                                               input logic [127:0] din);
      logic [127:0] s;
      if (op == aes_pkg::OP_ENCRYPT) begin
         s = din ^ model_keys[0];
         for (int r = 1; r < 10; r++) s = mix_cols(sub_rows(s, 0), 0) ^ model_keys[r];
         s = sub_rows(s, 0) ^ model_keys[10];
      end else begin
         s = din ^ model_keys[10];
         for (int r = 9; r >= 1; r--) s = mix_cols(sub_rows(s, 1) ^ model_keys[r], 1);
         s = sub_rows(s, 1) ^ model_keys[0];
      end
      return s;
   endfunction

   task automatic write_key(input aes_pkg::csr_index_type idx, input logic [63:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == aes_pkg::CSR_KEY_HIGH) key_hi_q = value;
      else key_lo_q = value;
      expand_keys();
   endtask

   // key writes only once the pipeline has drained
   task automatic rekey(input logic [63:0] hi, input logic [63:0] lo,
                        input bit wr_hi, input bit wr_lo);
      start = 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (KeySettle) @(negedge clock);
      if (wr_hi) write_key(aes_pkg::CSR_KEY_HIGH, hi);
      if (wr_lo) write_key(aes_pkg::CSR_KEY_LOW, lo);
      repeat (KeySettle) @(negedge clock);
   endtask

   task automatic send_block(input aes_pkg::op_type op, input logic [63:0] hi,
                             input logic [63:0] lo, input bit known,
                             input logic [127:0] want);
      int gap;
      logic [127:0] res;
      case ($urandom_range(0, 19)) inside
         [0:10]: gap = 0;
         [11:17]: gap = $urandom_range(1, 3);
         default: gap = $urandom_range(10, 40);
      endcase
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_data_high = hi;
      req_data_low = lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = known ? want : aes_cipher(op, {hi, lo});
      pending_blocks.push_back('{hi: res[127:64], lo: res[63:0]});
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_edge64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {32{2'b10}};
         default: return rand64();
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      block_type exp_blk;
      if (!reset && rsp_valid) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected result %h_%h", $time, rsp_out_high, rsp_out_low);
            errors++;
         end else begin
            exp_blk = pending_blocks.pop_front();
            if (rsp_out_high !== exp_blk.hi) begin
               $display("%0t: out_high expected %h actual %h", $time, exp_blk.hi,
                        rsp_out_high);
               errors++;
            end
            if (rsp_out_low !== exp_blk.lo) begin
               $display("%0t: out_low expected %h actual %h", $time, exp_blk.lo,
                        rsp_out_low);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      kat_row_type kat [$];
      kat_row_type row;
      bit first;
      logic [63:0] khi;
      logic [63:0] klo;
      int mode;
      int left;
      errors = 0;
      stall_cycles = 0;
      first = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_operation = aes_pkg::OP_ENCRYPT;
      req_data_high = '0;
      req_data_low = '0;
      csr_write = 1'b0;
      csr_index = aes_pkg::CSR_KEY_HIGH;
      csr_wdata = '0;
      key_hi_q = '0;
      key_lo_q = '0;
      build_boxes();
      expand_keys();

      kat.push_back('{'0, '0, aes_pkg::OP_ENCRYPT, '0, '0, 1,
                      64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
      kat.push_back('{'0, '0, aes_pkg::OP_DECRYPT, 64'h66e94bd4ef8a2c3b,
                      64'h884cfa59ca342b2e, 1, '0, '0});
      kat.push_back('{'0, '0, aes_pkg::OP_ENCRYPT, '1, '1, 0, '0, '0});
      kat.push_back('{'0, '0, aes_pkg::OP_DECRYPT, '1, '1, 0, '0, '0});
      kat.push_back('{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_ENCRYPT,
                      64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
      kat.push_back('{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_DECRYPT,
                      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                      64'h0011223344556677, 64'h8899aabbccddeeff});
      kat.push_back('{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_ENCRYPT,
                      '0, '1, 0, '0, '0});
      kat.push_back('{'1, '1, aes_pkg::OP_ENCRYPT, '0, '0, 0, '0, '0});
      kat.push_back('{'1, '1, aes_pkg::OP_ENCRYPT, '1, '1, 0, '0, '0});
      kat.push_back('{'1, '1, aes_pkg::OP_DECRYPT, '0, '0, 0, '0, '0});
      kat.push_back('{'1, '1, aes_pkg::OP_DECRYPT, '1, '0, 0, '0, '0});
      kat.push_back('{'1, '0, aes_pkg::OP_ENCRYPT, {32{2'b10}}, {32{2'b01}}, 0, '0, '0});
      kat.push_back('{'0, '1, aes_pkg::OP_DECRYPT, {32{2'b01}}, {32{2'b10}}, 0, '0, '0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (kat[i]) begin
         row = kat[i];
         if (first || row.key_hi != key_hi_q || row.key_lo != key_lo_q) begin
            rekey(row.key_hi, row.key_lo, first || row.key_hi != key_hi_q,
                  first || row.key_lo != key_lo_q);
            first = 1'b0;
         end
         send_block(row.op, row.din_hi, row.din_lo, row.known, {row.dout_hi, row.dout_lo});
      end

      left = RandBlocks;
      while (left > 0) begin
         mode = $urandom_range(0, 5);
         khi = (mode == 0) ? '1 : (mode == 1) ? '0 : rand64();
         klo = (mode == 0) ? '1 : (mode == 1) ? '0 : rand64();
         // sometimes rewrite only one half of the key
         case ($urandom_range(0, 3))
            0: rekey(khi, klo, 1, 0);
            1: rekey(khi, klo, 0, 1);
            default: rekey(khi, klo, 1, 1);
         endcase
         for (int n = $urandom_range(40, 160); n > 0 && left > 0; n--) begin
            send_block($urandom_range(0, 1) ? aes_pkg::OP_DECRYPT : aes_pkg::OP_ENCRYPT,
                       rand_edge64(), rand_edge64(), 0, '0);
            left--;
         end
      end
      start = 1'b0;

      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
